>>> rtl/core/modular_dot_product_core_defines.svh
// Assertion macros shared by the modular dot product RTL.
`ifndef MODULAR_DOT_PRODUCT_CORE_DEFINES_SVH
`define MODULAR_DOT_PRODUCT_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define MDP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("modular_dot_product assertion failed");

// Next-cycle implication, disabled while reset is low.
`define MDP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("modular_dot_product assertion failed");

`endif

>>> rtl/core/mdp_pkg.sv
// Types and fixed widths of the modular dot product core.
package mdp_pkg;

    localparam int ROW_W = 31;   // signed row element
    localparam int VEC_W = 30;   // unsigned vector coefficient
    localparam int DOT_W = 30;   // result word
    localparam int MOD_W = 31;   // modulus register
    localparam int T_W   = 62;   // signed product plus running sum
    localparam int MAG_W = 61;   // magnitude of that sum
    localparam int CNT_W = $clog2(MAG_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_ABS,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rem_stat_t;

endpackage

>>> rtl/core/modular_dot_product_core.sv
// Top level of the modular dot product core: sequencer, multiply-add and result word.
//
// Each accepted word (signed row element, vector coefficient, last flag) is
// multiplied and added to the running sum, then reduced by the modulus with a
// remainder that truncates toward zero. s_ready is low while a word is in work;
// each word passes through the multiply, the add, the absolute value, the
// 61-step bit-serial remainder loop of mdp_rem_unit, done detection and
// write-back before the idle state takes the next word. On a word with last
// set the reduced sum, shifted into 0..q-1, goes to the m_ channel and the
// sum clears; a new word may be taken while that result waits. A modulus of
// zero acts as one and values above 2^MOD_BITS saturate there. The modulus
// is sampled when a word starts, so write it only while the core is idle.
`include "modular_dot_product_core_defines.svh"

module modular_dot_product_core #(
    parameter int MOD_BITS = 30
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [mdp_pkg::MOD_W-1:0]         cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [mdp_pkg::ROW_W-1:0]  s_row_elem,
    input  logic [mdp_pkg::VEC_W-1:0]         s_vec_elem,
    input  logic                              s_last_elem,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mdp_pkg::DOT_W-1:0]         m_dot_mod
);

    localparam int CAP_W = mdp_pkg::MOD_W + 1;
    localparam logic [CAP_W-1:0] CAP = CAP_W'(1) << MOD_BITS;

    mdp_pkg::state_t                    state_reg, state_next;
    logic [mdp_pkg::MOD_W-1:0]          modulus_reg, modulus_next;
    logic [MOD_BITS:0]                  q_reg, q_next;
    logic signed [mdp_pkg::ROW_W-1:0]   row_reg, row_next;
    logic [mdp_pkg::VEC_W-1:0]          vec_reg, vec_next;
    logic                               last_reg, last_next;
    logic signed [mdp_pkg::T_W-1:0]     prod_reg, prod_next;
    logic signed [mdp_pkg::T_W-1:0]     t_reg, t_next;
    logic                               sum_neg_reg, sum_neg_next;
    logic [MOD_BITS-1:0]                sum_mag_reg, sum_mag_next;
    logic                               m_valid_reg, m_valid_next;
    logic [mdp_pkg::DOT_W-1:0]          m_dot_reg, m_dot_next;

    logic [CAP_W-1:0]                   m_ext;
    logic [CAP_W-1:0]                   q_wide;
    logic signed [mdp_pkg::T_W-1:0]     prod_full;
    logic signed [mdp_pkg::T_W-1:0]     sum_ext;
    logic signed [mdp_pkg::T_W-1:0]     t_abs;
    logic                               accept;
    logic                               div_start;
    mdp_pkg::rem_stat_t                 div_stat;
    logic [MOD_BITS-1:0]                div_rem;
    logic                               res_neg;
    logic [MOD_BITS:0]                  res_val;

    assign accept    = s_valid && s_ready;
    assign m_ext     = {1'b0, modulus_reg};
    assign q_wide    = (m_ext == '0) ? CAP_W'(1) : ((m_ext > CAP) ? CAP : m_ext);
    assign prod_full = row_reg * $signed({1'b0, vec_reg});
    assign sum_ext   = $signed({{(mdp_pkg::T_W - MOD_BITS){1'b0}}, sum_mag_reg});
    assign t_abs     = t_reg[mdp_pkg::T_W-1] ? -t_reg : t_reg;
    assign res_neg   = t_reg[mdp_pkg::T_W-1] && (div_rem != '0);
    assign res_val   = res_neg ? (q_reg - {1'b0, div_rem}) : {1'b0, div_rem};

    mdp_rem_unit #(
        .MOD_BITS(MOD_BITS)
    ) u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .mag     (t_abs[mdp_pkg::MAG_W-1:0]),
        .q       (q_reg),
        .stat    (div_stat),
        .rem     (div_rem)
    );

    always_comb begin
        state_next   = state_reg;
        modulus_next = cfg_wr_en ? cfg_wr_data : modulus_reg;
        q_next       = q_reg;
        row_next     = row_reg;
        vec_next     = vec_reg;
        last_next    = last_reg;
        prod_next    = prod_reg;
        t_next       = t_reg;
        sum_neg_next = sum_neg_reg;
        sum_mag_next = sum_mag_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_dot_next   = m_dot_reg;
        div_start    = 1'b0;
        s_ready      = 1'b0;
        unique case (state_reg)
            mdp_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    row_next   = s_row_elem;
                    vec_next   = s_vec_elem;
                    last_next  = s_last_elem;
                    state_next = mdp_pkg::ST_MUL;
                end
            end
            mdp_pkg::ST_MUL: begin
                prod_next  = prod_full;
                q_next     = q_wide[MOD_BITS:0];
                state_next = mdp_pkg::ST_ADD;
            end
            mdp_pkg::ST_ADD: begin
                t_next     = sum_neg_reg ? (prod_reg - sum_ext) : (prod_reg + sum_ext);
                state_next = mdp_pkg::ST_ABS;
            end
            mdp_pkg::ST_ABS: begin
                div_start  = 1'b1;
                state_next = mdp_pkg::ST_DIV;
            end
            mdp_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    state_next = mdp_pkg::ST_FIN;
                end
            end
            mdp_pkg::ST_FIN: begin
                if (!last_reg) begin
                    sum_neg_next = res_neg;
                    sum_mag_next = div_rem;
                    state_next   = mdp_pkg::ST_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_dot_next   = mdp_pkg::DOT_W'(res_val);
                    sum_neg_next = 1'b0;
                    sum_mag_next = '0;
                    state_next   = mdp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mdp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mdp_pkg::ST_IDLE;
            modulus_reg <= mdp_pkg::MOD_W'(2);
            q_reg       <= (MOD_BITS + 1)'(2);
            sum_neg_reg <= 1'b0;
            sum_mag_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            modulus_reg <= modulus_next;
            q_reg       <= q_next;
            sum_neg_reg <= sum_neg_next;
            sum_mag_reg <= sum_mag_next;
            m_valid_reg <= m_valid_next;
        end
        row_reg   <= row_next;
        vec_reg   <= vec_next;
        last_reg  <= last_next;
        prod_reg  <= prod_next;
        t_reg     <= t_next;
        m_dot_reg <= m_dot_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_dot_mod = m_dot_reg;

    `MDP_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, accept, !s_ready)
    `MDP_ASSERT_NOW(a_sum_below_q, aclk, aresetn, state_reg == mdp_pkg::ST_IDLE, ({1'b0, sum_mag_reg} < q_reg))
    `MDP_ASSERT_NOW(a_div_busy_in_div, aclk, aresetn, div_stat.busy, state_reg == mdp_pkg::ST_DIV)

endmodule

>>> rtl/core/mdp_rem_unit.sv
// Bit-serial restoring remainder: one compare and subtract per cycle.
`include "modular_dot_product_core_defines.svh"

module mdp_rem_unit #(
    parameter int MOD_BITS = 30
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [mdp_pkg::MAG_W-1:0]      mag,
    input  logic [MOD_BITS:0]              q,
    output mdp_pkg::rem_stat_t             stat,
    output logic [MOD_BITS-1:0]            rem
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [mdp_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [mdp_pkg::MAG_W-1:0]     mag_reg, mag_next;
    logic [MOD_BITS-1:0]           rem_reg, rem_next;
    logic [MOD_BITS:0]             trial;
    logic [MOD_BITS:0]             diff;

    assign trial = {rem_reg, mag_reg[mdp_pkg::MAG_W-1]};
    assign diff  = trial - q;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = mdp_pkg::CNT_W'(mdp_pkg::MAG_W - 1);
            mag_next  = mag;
            rem_next  = '0;
        end else if (busy_reg) begin
            mag_next = {mag_reg[mdp_pkg::MAG_W-2:0], 1'b0};
            rem_next = (trial >= q) ? diff[MOD_BITS-1:0] : trial[MOD_BITS-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        mag_reg <= mag_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign rem       = rem_reg;

    `MDP_ASSERT_NOW(a_start_when_free, aclk, aresetn, start, !busy_reg && !done_reg)
    `MDP_ASSERT_NOW(a_rem_below_q, aclk, aresetn, done_reg, {1'b0, rem_reg} < q)

endmodule

>>> sim/tb_modular_dot_product_core.sv
// Self-checking testbench for the modular dot product core: directed table, random rows.
module tb_modular_dot_product_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MOD_BITS    = 30;
    localparam int SETTLE_CYC  = 80;
    localparam int HOLD_CYCLES = 1500;
    localparam int N_DIR       = 20;
    localparam int N_PHASES    = 10;

    localparam logic [mdp_pkg::MOD_W-1:0] MOD_CAP  = 31'h4000_0000;
    localparam logic [mdp_pkg::MOD_W-1:0] MOD_FULL = 31'h7fff_ffff;
    localparam logic [mdp_pkg::VEC_W-1:0] VEC_MAX  = 30'h3fff_ffff;
    localparam logic [mdp_pkg::DOT_W-1:0] DOT_MAX  = 30'h3fff_ffff;
    localparam logic signed [mdp_pkg::ROW_W-1:0] ROW_MAX = 31'sd1073741823;
    localparam logic signed [mdp_pkg::ROW_W-1:0] ROW_MIN = 31'h4000_0000;

    typedef struct {
        logic [mdp_pkg::MOD_W-1:0]        modv;
        logic signed [mdp_pkg::ROW_W-1:0] row;
        logic [mdp_pkg::VEC_W-1:0]        vec;
        bit                               last;
        bit                               typed;
        logic [mdp_pkg::DOT_W-1:0]        dot;
    } dir_row_t;

    logic                             aclk        = 1'b0;
    logic                             aresetn     = 1'b0;
    logic                             cfg_wr_en   = 1'b0;
    logic [mdp_pkg::MOD_W-1:0]        cfg_wr_data = '0;
    logic                             s_valid     = 1'b0;
    logic                             s_ready;
    logic signed [mdp_pkg::ROW_W-1:0] s_row_elem  = '0;
    logic [mdp_pkg::VEC_W-1:0]        s_vec_elem  = '0;
    logic                             s_last_elem = 1'b0;
    logic                             m_valid;
    logic                             m_ready     = 1'b0;
    logic [mdp_pkg::DOT_W-1:0]        m_dot_mod;

    logic [mdp_pkg::MOD_W-1:0] mod_reg = 31'd2;
    longint                    run_sum = 0;
    logic [mdp_pkg::DOT_W-1:0] dot_q[$];
    dir_row_t                  dir_tab [0:N_DIR-1];

    int  mismatches   = 0;
    int  words_sent   = 0;
    int  rows_sent    = 0;
    int  mod_writes   = 0;
    int  tx_idle_pct  = 0;
    int  rx_stall_pct = 0;
    bit  hold_req     = 1'b0;
    int  hold_cnt     = 0;

    modular_dot_product_core #(.MOD_BITS(MOD_BITS)) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_row_elem  (s_row_elem),
        .s_vec_elem  (s_vec_elem),
        .s_last_elem (s_last_elem),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_dot_mod   (m_dot_mod)
    );

    always #1 aclk = ~aclk;

    function automatic longint eff_modulus();
        longint m;
        m = longint'(mod_reg);
        if (m == 0) begin
            m = 1;
        end
        if (m > (longint'(1) << MOD_BITS)) begin
            m = longint'(1) << MOD_BITS;
        end
        return m;
    endfunction

    // Multiply-accumulate, truncating remainder, and row result on last.
    task automatic accumulate_word(input logic signed [mdp_pkg::ROW_W-1:0] row,
                                   input logic [mdp_pkg::VEC_W-1:0] vec, input bit last,
                                   input bit typed,
                                   input logic [mdp_pkg::DOT_W-1:0] typed_dot);
        longint q;
        longint s;
        q = eff_modulus();
        s = run_sum + longint'(row) * longint'(vec);
        s = s % q;
        run_sum = s;
        if (last) begin
            if (s < 0) begin
                s = s + q;
            end
            dot_q.push_back(typed ? typed_dot : s[mdp_pkg::DOT_W-1:0]);
            run_sum = 0;
            rows_sent++;
        end
    endtask

    task automatic send_word(input logic signed [mdp_pkg::ROW_W-1:0] row,
                             input logic [mdp_pkg::VEC_W-1:0] vec,
                             input bit last, input bit typed,
                             input logic [mdp_pkg::DOT_W-1:0] typed_dot);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_row_elem  <= row;
        s_vec_elem  <= vec;
        s_last_elem <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        accumulate_word(row, vec, last, typed, typed_dot);
        words_sent++;
    endtask

    task automatic drain_core();
        s_valid <= 1'b0;
        while (dot_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_modulus(input logic [mdp_pkg::MOD_W-1:0] m);
        drain_core();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        mod_reg = m;
        mod_writes++;
    endtask

    task automatic random_word(output logic signed [mdp_pkg::ROW_W-1:0] row,
                               output logic [mdp_pkg::VEC_W-1:0] vec, output bit last);
        longint                    q;
        logic [mdp_pkg::VEC_W-1:0] mag;
        q = eff_modulus();
        if ($urandom_range(99) < 15) begin
            row = mdp_pkg::ROW_W'($urandom);
            vec = mdp_pkg::VEC_W'($urandom);
        end else begin
            mag = mdp_pkg::VEC_W'($urandom_range(32'(q - 1)));
            row = $urandom_range(1) ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            vec = mdp_pkg::VEC_W'($urandom_range(32'(q - 1)));
        end
        last = ($urandom_range(3) == 0);
    endtask

    // result side: check accepted words, drive m_ready
    always @(posedge aclk) begin
        logic [mdp_pkg::DOT_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (dot_q.size() == 0) begin
                $error("dot_mod: no word expected, actual %0d", m_dot_mod);
                mismatches++;
            end else begin
                want = dot_q.pop_front();
                if (m_dot_mod !== want) begin
                    $error("dot_mod: expected %0d, actual %0d", want, m_dot_mod);
                    mismatches++;
                end
            end
        end
        if (hold_req && hold_cnt < HOLD_CYCLES) begin
            hold_cnt <= hold_cnt + 1;
            m_ready  <= 1'b0;
        end else if ($urandom_range(99) < rx_stall_pct) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        #4_000_000;
        $display("tb_modular_dot_product_core failed");
        $finish;
    end

    initial begin
        logic signed [mdp_pkg::ROW_W-1:0] row;
        logic [mdp_pkg::VEC_W-1:0]        vec;
        bit                               last;
        logic [mdp_pkg::MOD_W-1:0]        m;
        int                               n_items;

        dir_tab = '{
            '{31'd2,    31'sd3,      30'd5,   1'b1, 1'b1, 30'd1},
            '{31'd2,    -31'sd1,     30'd1,   1'b1, 1'b1, 30'd1},
            '{31'd2,    31'sd0,      30'd0,   1'b1, 1'b1, 30'd0},
            '{31'd2,    31'sd1,      30'd1,   1'b0, 1'b0, 30'd0},
            '{31'd2,    31'sd1,      30'd3,   1'b1, 1'b0, 30'd0},
            '{MOD_CAP,  ROW_MAX,     VEC_MAX, 1'b1, 1'b1, 30'd1},
            '{MOD_CAP,  -ROW_MAX,    VEC_MAX, 1'b1, 1'b1, DOT_MAX},
            '{MOD_CAP,  ROW_MIN,     30'd1,   1'b1, 1'b1, 30'd0},
            '{MOD_CAP,  31'sd12345,  30'd678, 1'b0, 1'b0, 30'd0},
            '{MOD_CAP,  -31'sd99999, 30'd4321, 1'b0, 1'b0, 30'd0},
            '{MOD_CAP,  31'sd7,      30'd7,   1'b1, 1'b0, 30'd0},
            '{31'd0,    31'sd123,    30'd456, 1'b1, 1'b1, 30'd0},
            '{31'd0,    -31'sd5,     30'd9,   1'b1, 1'b1, 30'd0},
            '{MOD_FULL, -31'sd1,     30'd1,   1'b1, 1'b1, DOT_MAX},
            '{MOD_FULL, ROW_MAX,     30'd0,   1'b1, 1'b1, 30'd0},
            '{31'd1,    31'sd5,      30'd5,   1'b1, 1'b1, 30'd0},
            '{31'd7,    31'sd100,    30'd200, 1'b0, 1'b0, 30'd0},
            '{31'd7,    -31'sd300,   30'd50,  1'b1, 1'b0, 30'd0},
            '{31'd7,    ROW_MIN,     VEC_MAX, 1'b1, 1'b0, 30'd0},
            '{31'h3fff_ffff, ROW_MAX, 30'd1,  1'b1, 1'b1, 30'd0}
        };

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIR; i++) begin
            if (dir_tab[i].modv != mod_reg) begin
                write_modulus(dir_tab[i].modv);
            end
            send_word(dir_tab[i].row, dir_tab[i].vec, dir_tab[i].last,
                      dir_tab[i].typed, dir_tab[i].dot);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: m = MOD_CAP;
                1: m = mdp_pkg::MOD_W'($urandom_range(32'h4000_0000, 2));
                2: m = 31'd1;
                3: m = 31'h3fff_ffff;
                4: m = 31'd0;
                5: m = mdp_pkg::MOD_W'($urandom_range(1000, 2));
                6: m = MOD_FULL;
                7: m = mdp_pkg::MOD_W'($urandom);
                8: m = 31'd2;
                default: m = mdp_pkg::MOD_W'($urandom_range(32'h4000_0000, 2));
            endcase
            write_modulus(m);
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
                default: begin tx_idle_pct = 6; rx_stall_pct = 6; end
            endcase
            if (ph == 0) begin
                hold_req = 1'b1;
            end
            n_items = (m <= 31'd1) ? 40 : 155;
            for (int k = 0; k < n_items; k++) begin
                random_word(row, vec, last);
                send_word(row, vec, last, 1'b0, '0);
            end
        end

        drain_core();
        $display("%0d words in %0d rows checked across %0d modulus writes",
                 words_sent, rows_sent, mod_writes);
        $display("sender gaps, receiver stalls and a %0d-cycle output hold were exercised",
                 HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("tb_modular_dot_product_core passed");
        end else begin
            $display("tb_modular_dot_product_core failed");
        end
        $finish;
    end

endmodule
